// ----- design/srld_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// srld_pkg
// Shared types, character codes and result codes of the S-record decoder.
// ----------------------------------------------------------------------------
package srld_pkg;

    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_S    = 8'h53;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_THREE = 8'h33;
    localparam logic [7:0] CHAR_UA   = 8'h41;
    localparam logic [7:0] CHAR_UF   = 8'h46;
    localparam logic [7:0] CHAR_LA   = 8'h61;
    localparam logic [7:0] CHAR_LF_HEX = 8'h66;
    localparam logic [7:0] SUM_GOOD  = 8'hFF;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_OK   = 2'd1,
        KIND_BAD  = 2'd2,
        KIND_FMT  = 2'd3
    } result_kind_t;

    typedef struct packed {
        logic         valid;
        result_kind_t kind;
        logic [1:0]   record_kind;
        logic [31:0]  address;
        logic [7:0]   data;
    } result_t;

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
            d = c - CHAR_ZERO;
        else if (c >= CHAR_UA && c <= CHAR_UF)
            d = c - CHAR_UA + 8'd10;
        else if (c >= CHAR_LA && c <= CHAR_LF_HEX)
            d = c - CHAR_LA + 8'd10;
        return d[3:0];
    endfunction

    function automatic logic [2:0] addr_bytes(input logic [1:0] t);
        logic [2:0] n;
        unique case (t)
            2'd2:    n = 3'd3;
            2'd3:    n = 3'd4;
            default: n = 3'd2;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

// ----- design/srld_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// srld_parser
// Record state machine: consumes one character per step and produces at
// most one result for it.
// ----------------------------------------------------------------------------
module srld_parser
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        char_in,
    output srld_pkg::result_t      result
);
    import srld_pkg::*;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_TYPE  = 3'd1,
        PH_COUNT = 3'd2,
        PH_ADDR  = 3'd3,
        PH_DATA  = 3'd4,
        PH_CKSUM = 3'd5,
        PH_SKIP  = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  rec_type_reg, rec_type_next;
    logic [7:0]  count_reg, count_next;
    logic [31:0] start_addr_reg, start_addr_next;
    logic [3:0]  high_nibble_reg, high_nibble_next;
    logic        second_reg, second_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  offset_reg, offset_next;
    logic [7:0]  sum_reg, sum_next;

    logic        lf;
    logic [3:0]  nib;
    logic [7:0]  byte_val;
    logic [7:0]  ab8;
    logic [7:0]  left_dec;
    logic [7:0]  data_left;
    logic [7:0]  sum_add;

    assign lf        = (char_in == CHAR_LF);
    assign nib       = digit_value(char_in);
    assign byte_val  = {high_nibble_reg, nib};
    assign ab8       = {5'd0, addr_bytes(rec_type_reg)};
    assign left_dec  = left_reg - 8'd1;
    assign data_left = count_reg - ab8 - 8'd1;
    assign sum_add   = sum_reg + byte_val;

    always_comb
    begin
        phase_next       = phase_reg;
        rec_type_next    = rec_type_reg;
        count_next       = count_reg;
        start_addr_next  = start_addr_reg;
        high_nibble_next = high_nibble_reg;
        second_next      = second_reg;
        left_next        = left_reg;
        offset_next      = offset_reg;
        sum_next         = sum_reg;
        result           = '0;

        // digit collection common to the byte phases
        if (!lf && (phase_reg == PH_COUNT || phase_reg == PH_ADDR ||
                    phase_reg == PH_DATA || phase_reg == PH_CKSUM))
        begin
            if (!second_reg)
            begin
                high_nibble_next = nib;
                second_next      = 1'b1;
            end
            else
            begin
                second_next = 1'b0;
            end
        end

        unique case (phase_reg)
            PH_START:
            begin
                if (!lf && char_in != CHAR_CR)
                begin
                    if (char_in != CHAR_S)
                    begin
                        result.valid = 1'b1;
                        result.kind  = KIND_FMT;
                        phase_next   = PH_SKIP;
                        second_next  = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_TYPE;
                    end
                end
            end
            PH_TYPE:
            begin
                result.kind = KIND_FMT;
                second_next = 1'b0;
                if (lf)
                begin
                    result.valid = 1'b1;
                    phase_next   = PH_START;
                end
                else if (char_in < CHAR_ZERO || char_in > CHAR_THREE)
                begin
                    result.valid = 1'b1;
                    phase_next   = PH_SKIP;
                end
                else
                begin
                    rec_type_next = char_in[1:0];
                    phase_next    = PH_COUNT;
                end
            end
            PH_COUNT:
            begin
                result.kind = KIND_FMT;
                if (lf)
                begin
                    result.valid = 1'b1;
                    phase_next   = PH_START;
                    second_next  = 1'b0;
                end
                else if (second_reg)
                begin
                    count_next = byte_val;
                    if (byte_val < ab8 + 8'd1)
                    begin
                        result.valid = 1'b1;
                        phase_next   = PH_SKIP;
                    end
                    else
                    begin
                        sum_next        = byte_val;
                        start_addr_next = '0;
                        left_next       = ab8;
                        phase_next      = PH_ADDR;
                    end
                end
            end
            PH_ADDR:
            begin
                result.kind = KIND_FMT;
                if (lf)
                begin
                    result.valid = 1'b1;
                    phase_next   = PH_START;
                    second_next  = 1'b0;
                end
                else if (second_reg)
                begin
                    start_addr_next = {start_addr_reg[23:0], byte_val};
                    sum_next        = sum_add;
                    if (left_dec == 8'd0)
                    begin
                        left_next   = data_left;
                        offset_next = 8'd0;
                        phase_next  = (data_left == 8'd0) ? PH_CKSUM : PH_DATA;
                    end
                    else
                    begin
                        left_next = left_dec;
                    end
                end
            end
            PH_DATA:
            begin
                if (lf)
                begin
                    result.valid = 1'b1;
                    result.kind  = KIND_FMT;
                    phase_next   = PH_START;
                    second_next  = 1'b0;
                end
                else if (second_reg)
                begin
                    result.valid       = 1'b1;
                    result.kind        = KIND_DATA;
                    result.record_kind = rec_type_reg;
                    result.address     = start_addr_reg + {24'd0, offset_reg};
                    result.data        = byte_val;
                    sum_next           = sum_add;
                    offset_next        = offset_reg + 8'd1;
                    left_next          = left_dec;
                    if (left_dec == 8'd0)
                        phase_next = PH_CKSUM;
                end
            end
            PH_CKSUM:
            begin
                if (lf)
                begin
                    result.valid = 1'b1;
                    result.kind  = KIND_FMT;
                    phase_next   = PH_START;
                    second_next  = 1'b0;
                end
                else if (second_reg)
                begin
                    result.valid       = 1'b1;
                    result.kind        = (sum_add == SUM_GOOD) ? KIND_OK : KIND_BAD;
                    result.record_kind = rec_type_reg;
                    result.address     = start_addr_reg;
                    sum_next           = sum_add;
                    phase_next         = PH_SKIP;
                end
            end
            default:
            begin
                if (lf)
                begin
                    phase_next  = PH_START;
                    second_next = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_START;
            rec_type_reg    <= 2'd0;
            count_reg       <= 8'd0;
            start_addr_reg  <= 32'd0;
            high_nibble_reg <= 4'd0;
            second_reg      <= 1'b0;
            left_reg        <= 8'd0;
            offset_reg      <= 8'd0;
            sum_reg         <= 8'd0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            rec_type_reg    <= rec_type_next;
            count_reg       <= count_next;
            start_addr_reg  <= start_addr_next;
            high_nibble_reg <= high_nibble_next;
            second_reg      <= second_next;
            left_reg        <= left_next;
            offset_reg      <= offset_next;
            sum_reg         <= sum_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/srecord_line_decoder_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// srecord_line_decoder_top
// Streaming S-record decoder: one ASCII character in, at most one result out.
// ----------------------------------------------------------------------------
// Takes one character per cycle with no gaps while out_ready keeps up. A
// character is held in an input register, parsed by the record state machine
// once it can advance, and its result (data byte with address, record ok,
// checksum error or format error) lands in an output register. Characters
// that give no result are simply consumed. The output register only holds
// the input back while a result waits and out_ready is low.
// ----------------------------------------------------------------------------
module srecord_line_decoder_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  char_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       result_kind,
    output logic [1:0]       record_kind,
    output logic [31:0]      byte_address,
    output logic [7:0]       data_byte
);
    import srld_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  char_reg;
    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [1:0]  rec_kind_reg;
    logic [31:0] addr_reg;
    logic [7:0]  data_reg;
    logic        advance;
    result_t     result;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    srld_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .char_in (char_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance && result.valid)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            char_reg <= char_in;
        if (advance && result.valid)
        begin
            kind_reg     <= result.kind;
            rec_kind_reg <= result.record_kind;
            addr_reg     <= result.address;
            data_reg     <= result.data;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign record_kind  = rec_kind_reg;
    assign byte_address = addr_reg;
    assign data_byte    = data_reg;

endmodule
`default_nettype wire
